@@ hdl/cbm_pkg.sv @@
// Shared types and constants for the cartridge bank mapper.
package cbm_pkg;

  localparam int SENSOR_DEPTH = 128;
  localparam int RAM_DEPTH    = 512;
  localparam int SENSOR_AW    = $clog2(SENSOR_DEPTH);
  localparam int RAM_AW       = $clog2(RAM_DEPTH);
  localparam int BANK_W       = 9;
  localparam int COUNT_W      = 10;
  localparam int STEP_W       = $clog2(BANK_W + 1);
  localparam int ROM_OFF_W    = 14;
  localparam int ROM_ADDR_W   = BANK_W + ROM_OFF_W;
  localparam int ADDR_W       = 16;
  localparam int BYTE_W       = 8;

  localparam logic [COUNT_W-1:0] MAX_ROM_BANKS  = 10'd512;
  localparam logic [3:0]         RAM_ENABLE_KEY = 4'hA;
  localparam logic [7:0]         RAM_WIN_BASE   = 8'h80;
  localparam logic [BYTE_W-1:0]  NO_DATA        = 8'hFF;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_MOD   = 5'b00100,
    ST_MEM   = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

endpackage

@@ hdl/cbm_ram.sv @@
// Generic single-port-write, registered-read RAM.
module cbm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hdl/cbm_mod_unit.sv @@
// Bit-serial remainder unit for the ROM bank modulo the bank count.
module cbm_mod_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [cbm_pkg::BANK_W-1:0]  dividend,
  input  logic [cbm_pkg::COUNT_W-1:0] divisor,
  output logic                        done,
  output logic [cbm_pkg::BANK_W-1:0]  remainder
);
  import cbm_pkg::*;

  logic                busy;
  logic [STEP_W-1:0]   step;
  logic [BANK_W-1:0]   dvd;
  logic [COUNT_W-1:0]  dsr;
  logic [BANK_W-1:0]   remainder_next;
  logic [BANK_W:0]     trial;

  assign trial = {remainder, dvd[BANK_W-1]};

  always_comb begin
    if (trial >= (BANK_W + 1)'(dsr)) begin
      remainder_next = BANK_W'(trial - (BANK_W + 1)'(dsr));
    end else begin
      remainder_next = trial[BANK_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        remainder <= '0;
        dvd <= dividend;
        dsr <= divisor;
      end else if (busy) begin
        remainder <= remainder_next;
        dvd <= {dvd[BANK_W-2:0], 1'b0};
        step <= step + STEP_W'(1);
        if (step == STEP_W'(BANK_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ hdl/cartridge_bank_mapper.sv @@
// Top level of the cartridge bank mapper: bank registers, sensor and RAM stores.
// Writes, fixed ROM and unmapped reads go straight to the done state; sensor and RAM reads go
// through the memory state (registered memory read); banked ROM reads wait in the remainder
// state for the nine-step serial remainder unit. One access is in progress at a time; the next
// input transfer can be taken in the same cycle as the result is presented. Reset (rst,
// synchronous) clears the control, bank and config registers, then a pass zeroes both stores.
module cartridge_bank_mapper (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [cbm_pkg::COUNT_W-1:0]    cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           opcode,
  input  logic [cbm_pkg::ADDR_W-1:0]     bus_address,
  input  logic [cbm_pkg::BYTE_W-1:0]     write_byte,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [cbm_pkg::BYTE_W-1:0]     read_byte,
  output logic                           rom_fetch,
  output logic [cbm_pkg::ROM_ADDR_W-1:0] rom_byte_address
);
  import cbm_pkg::*;

  state_t              state;
  logic [RAM_AW-1:0]   clear_idx;
  logic [COUNT_W-1:0]  rom_bank_count;
  logic [7:0]          bank_low;
  logic                bank_high;
  logic [3:0]          ram_bank_select;
  logic                ram_enable;
  logic [BANK_W-1:0]   effective_bank;
  logic                is_sensor;
  logic [BYTE_W-1:0]   res_byte;
  logic                res_fetch;
  logic [ROM_ADDR_W-1:0] res_addr;

  logic                accept;
  logic                clearing;
  logic                cart_hit;
  logic                sensor_hit;
  logic [RAM_AW-1:0]   ram_index;
  logic [BANK_W-1:0]   bank_word;
  logic [7:0]          bank_low_next;
  logic                bank_high_next;
  logic [BANK_W-1:0]   bank_next;
  logic [COUNT_W-1:0]  count_eff;
  logic                mem_write;
  logic                sensor_we;
  logic [SENSOR_AW-1:0] sensor_waddr;
  logic                ram_we;
  logic [RAM_AW-1:0]   ram_waddr;
  logic [BYTE_W-1:0]   mem_wdata;
  logic [BYTE_W-1:0]   sensor_rdata;
  logic [BYTE_W-1:0]   ram_rdata;
  logic                mod_start;
  logic                mod_done;
  logic [BANK_W-1:0]   mod_rem;
  logic                out_free;

  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign clearing  = (state == ST_CLEAR);
  assign out_free  = !out_valid || !out_stall;

  assign cart_hit   = (bus_address[15:13] == 3'b101);
  assign sensor_hit = cart_hit && (bus_address[12:7] == 6'd0);
  assign ram_index  = {ram_bank_select[0], bus_address[7:0] - RAM_WIN_BASE};

  always_comb begin
    bank_low_next  = bank_low;
    bank_high_next = bank_high;
    if (bus_address[15:12] == 4'h2) begin
      bank_low_next = write_byte;
    end
    if (bus_address[15:12] == 4'h3) begin
      bank_high_next = write_byte[0];
    end
    bank_word = {bank_high_next, bank_low_next};
    bank_next = (bank_word == '0) ? BANK_W'(1) : bank_word;
  end

  always_comb begin
    if (rom_bank_count == '0) begin
      count_eff = COUNT_W'(1);
    end else if (rom_bank_count > MAX_ROM_BANKS) begin
      count_eff = MAX_ROM_BANKS;
    end else begin
      count_eff = rom_bank_count;
    end
  end

  assign mem_write    = accept && (opcode == OP_WRITE) && cart_hit && ram_enable;
  assign sensor_we    = clearing ? (clear_idx < RAM_AW'(SENSOR_DEPTH)) : (mem_write && sensor_hit);
  assign ram_we       = clearing || (mem_write && !sensor_hit);
  assign sensor_waddr = clearing ? clear_idx[SENSOR_AW-1:0] : bus_address[SENSOR_AW-1:0];
  assign ram_waddr    = clearing ? clear_idx : ram_index;
  assign mem_wdata    = clearing ? '0 : write_byte;

  assign mod_start = accept && (opcode == OP_READ) && (bus_address[15:14] == 2'b01);

  cbm_ram #(.WIDTH(BYTE_W), .DEPTH(SENSOR_DEPTH)) u_sensor (
    .clk   (clk),
    .we    (sensor_we),
    .waddr (sensor_waddr),
    .wdata (mem_wdata),
    .raddr (bus_address[SENSOR_AW-1:0]),
    .rdata (sensor_rdata)
  );

  cbm_ram #(.WIDTH(BYTE_W), .DEPTH(RAM_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (mem_wdata),
    .raddr (ram_index),
    .rdata (ram_rdata)
  );

  cbm_mod_unit u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (effective_bank),
    .divisor   (count_eff),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLEAR;
      clear_idx       <= '0;
      out_valid       <= 1'b0;
      rom_bank_count  <= COUNT_W'(1);
      bank_low        <= 8'd1;
      bank_high       <= 1'b0;
      ram_bank_select <= 4'd0;
      ram_enable      <= 1'b0;
      effective_bank  <= BANK_W'(1);
    end else begin
      if (cfg_write) begin
        rom_bank_count <= cfg_data;
      end
      if (state == ST_DONE) begin
        if (out_free) begin
          out_valid <= 1'b1;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clear_idx <= clear_idx + RAM_AW'(1);
          if (clear_idx == RAM_AW'(RAM_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (opcode == OP_WRITE) begin
              res_byte  <= NO_DATA;
              res_fetch <= 1'b0;
              res_addr  <= '0;
              state     <= ST_DONE;
              if (bus_address[15:13] == 3'b000) begin
                ram_enable <= (write_byte[3:0] == RAM_ENABLE_KEY);
              end
              if (bus_address[15:13] == 3'b001) begin
                bank_low       <= bank_low_next;
                bank_high      <= bank_high_next;
                effective_bank <= bank_next;
              end
              if (bus_address[15:13] == 3'b010) begin
                ram_bank_select <= write_byte[3:0];
              end
            end else if (bus_address[15:14] == 2'b00) begin
              res_byte  <= NO_DATA;
              res_fetch <= 1'b1;
              res_addr  <= ROM_ADDR_W'(bus_address[ROM_OFF_W-1:0]);
              state     <= ST_DONE;
            end else if (bus_address[15:14] == 2'b01) begin
              res_byte  <= NO_DATA;
              res_fetch <= 1'b1;
              res_addr  <= ROM_ADDR_W'(bus_address[ROM_OFF_W-1:0]);
              state     <= ST_MOD;
            end else if (cart_hit && ram_enable) begin
              res_fetch <= 1'b0;
              res_addr  <= '0;
              is_sensor <= sensor_hit;
              state     <= ST_MEM;
            end else begin
              res_byte  <= NO_DATA;
              res_fetch <= 1'b0;
              res_addr  <= '0;
              state     <= ST_DONE;
            end
          end
        end
        ST_MOD: begin
          if (mod_done) begin
            res_addr <= {mod_rem, res_addr[ROM_OFF_W-1:0]};
            state    <= ST_DONE;
          end
        end
        ST_MEM: begin
          res_byte <= is_sensor ? sensor_rdata : ram_rdata;
          state    <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            read_byte        <= res_byte;
            rom_fetch        <= res_fetch;
            rom_byte_address <= res_addr;
            state            <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/cbm_checker.sv @@
// Port-level assertions for the cartridge bank mapper, bound to its top level.
module cbm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           in_valid,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic [cbm_pkg::BYTE_W-1:0]     read_byte,
  input logic                           rom_fetch,
  input logic [cbm_pkg::ROM_ADDR_W-1:0] rom_byte_address
);
  import cbm_pkg::*;

  a_reset_clears_out: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("Result valid after reset.");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("Input taken while an access is in progress.");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(read_byte) && $stable(rom_fetch)
      && $stable(rom_byte_address)))
    else $error("Stalled result changed.");

  a_fetch_no_data: assert property (@(posedge clk) disable iff (rst)
    (out_valid && rom_fetch) |-> (read_byte == NO_DATA))
    else $error("ROM fetch carries a data byte.");

  a_no_fetch_no_addr: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !rom_fetch) |-> (rom_byte_address == '0))
    else $error("ROM address set without a fetch.");

endmodule

bind cartridge_bank_mapper cbm_checker u_cbm_checker (.*);
